/* rtl/core/rth_pkg.sv */
// Shared types and constants for the RGB to HSL converter.
`default_nettype none
package rth_pkg;

    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [1:0] {
        SEXT_0,
        SEXT_2,
        SEXT_4,
        SEXT_6
    } sext_t;

    typedef struct packed {
        logic valid;
        logic grey;
    } ctl_t;

endpackage
`default_nettype wire

/* rtl/core/rth_if.sv */
// Item channels: pixel in (RGB), pixel out (HSL).
`default_nettype none
interface rth_pix_if #(parameter int FRAC_BITS = 16);
    logic                 valid;
    logic                 ready;
    logic [FRAC_BITS:0]   red;
    logic [FRAC_BITS:0]   green;
    logic [FRAC_BITS:0]   blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rth_hsl_if #(parameter int FRAC_BITS = 16);
    logic                   valid;
    logic                   ready;
    logic [FRAC_BITS:0]     lightness;
    logic [FRAC_BITS:0]     saturation_out;
    logic [FRAC_BITS-1:0]   hue_out;
    modport source (output valid, lightness, saturation_out, hue_out, input ready);
    modport sink   (input valid, lightness, saturation_out, hue_out, output ready);
endinterface
`default_nettype wire

/* rtl/core/rth_prep.sv */
// Front end: clamp, max/min, sextant, then divisor and numerator set-up.
`default_nettype none
module rth_prep #(
    parameter int FRAC_BITS = rth_pkg::FRAC_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [FRAC_BITS:0]    red,
    input  wire logic [FRAC_BITS:0]    green,
    input  wire logic [FRAC_BITS:0]    blue,
    output rth_pkg::ctl_t              ctl,
    output logic [FRAC_BITS:0]         light,
    output logic [FRAC_BITS+3:0]       rem_s,
    output logic [FRAC_BITS+3:0]       div_s,
    output logic [FRAC_BITS+3:0]       rem_h,
    output logic [FRAC_BITS+3:0]       div_h
);
    import rth_pkg::*;

    localparam int W  = FRAC_BITS + 4;
    localparam int CW = FRAC_BITS + 1;
    localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

    logic [CW-1:0] r, g, b, mx, mn, part;
    sext_t         sext;
    logic          plus;

    logic          v0_reg;
    logic [CW-1:0] mx_reg, mn_reg, part_reg;
    sext_t         sext_reg;
    logic          plus_reg;

    logic [CW:0]   sum, other, dv;
    logic [CW-1:0] delta;
    logic [W-1:0]  base_d, num, d6;

    always_comb
    begin
        r = (red   > ONE) ? ONE : red;
        g = (green > ONE) ? ONE : green;
        b = (blue  > ONE) ? ONE : blue;
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        if (r >= g && g >= b)
        begin
            sext = SEXT_0; plus = 1'b1; part = g - mn;
        end
        else if (g >= r && r >= b)
        begin
            sext = SEXT_2; plus = 1'b0; part = r - mn;
        end
        else if (g >= b && b >= r)
        begin
            sext = SEXT_2; plus = 1'b1; part = b - mn;
        end
        else if (b >= g && g >= r)
        begin
            sext = SEXT_4; plus = 1'b0; part = g - mn;
        end
        else if (b >= r && r >= g)
        begin
            sext = SEXT_4; plus = 1'b1; part = r - mn;
        end
        else
        begin
            sext = SEXT_6; plus = 1'b0; part = b - mn;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg   <= mx;
            mn_reg   <= mn;
            part_reg <= part;
            sext_reg <= sext;
            plus_reg <= plus;
        end
    end

    always_comb
    begin
        sum   = {1'b0, mx_reg} + {1'b0, mn_reg};
        delta = mx_reg - mn_reg;
        other = {ONE, 1'b0} - sum;
        dv    = (sum < other) ? sum : other;
        d6    = (W'(delta) << 2) + (W'(delta) << 1);
        case (sext_reg)
            SEXT_0:  base_d = '0;
            SEXT_2:  base_d = W'(delta) << 1;
            SEXT_4:  base_d = W'(delta) << 2;
            SEXT_6:  base_d = d6;
            default: base_d = '0;
        endcase
        num = plus_reg ? base_d + W'(part_reg) : base_d - W'(part_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl <= '0;
        else if (en)
            ctl <= '{valid: v0_reg, grey: (delta == '0)};
    end

    // grey pixels get unit divisors; saturation and hue are forced to zero at the end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            light <= sum[CW:1];
            rem_s <= (delta == '0) ? '0 : W'(delta);
            div_s <= (delta == '0) ? W'(1) : W'(dv);
            rem_h <= (delta == '0) ? '0 : num;
            div_h <= (delta == '0) ? W'(1) : d6;
        end
    end
endmodule
`default_nettype wire

/* rtl/core/rth_div_cell.sv */
// One restoring-division step for saturation and hue, with pipeline register.
`default_nettype none
module rth_div_cell #(
    parameter int FRAC_BITS = rth_pkg::FRAC_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  rth_pkg::ctl_t              ctl_in,
    input  wire logic [FRAC_BITS:0]    light_in,
    input  wire logic [FRAC_BITS+3:0]  rem_s_in,
    input  wire logic [FRAC_BITS+3:0]  div_s_in,
    input  wire logic [FRAC_BITS+3:0]  rem_h_in,
    input  wire logic [FRAC_BITS+3:0]  div_h_in,
    input  wire logic [FRAC_BITS:0]    q_s_in,
    input  wire logic [FRAC_BITS:0]    q_h_in,
    output rth_pkg::ctl_t              ctl_reg,
    output logic [FRAC_BITS:0]         light_reg,
    output logic [FRAC_BITS+3:0]       rem_s_reg,
    output logic [FRAC_BITS+3:0]       div_s_reg,
    output logic [FRAC_BITS+3:0]       rem_h_reg,
    output logic [FRAC_BITS+3:0]       div_h_reg,
    output logic [FRAC_BITS:0]         q_s_reg,
    output logic [FRAC_BITS:0]         q_h_reg
);
    import rth_pkg::*;

    localparam int W = FRAC_BITS + 4;

    logic         bit_s, bit_h;
    logic [W-1:0] rs, rh;

    always_comb
    begin
        bit_s = (rem_s_in >= div_s_in);
        bit_h = (rem_h_in >= div_h_in);
        rs    = bit_s ? rem_s_in - div_s_in : rem_s_in;
        rh    = bit_h ? rem_h_in - div_h_in : rem_h_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            light_reg <= light_in;
            rem_s_reg <= rs << 1;
            rem_h_reg <= rh << 1;
            div_s_reg <= div_s_in;
            div_h_reg <= div_h_in;
            q_s_reg   <= {q_s_in[FRAC_BITS-1:0], bit_s};
            q_h_reg   <= {q_h_in[FRAC_BITS-1:0], bit_h};
        end
    end
endmodule
`default_nettype wire

/* rtl/core/rgb_to_hsl.sv */
// Top level: RGB to HSL pixel converter.
// One pixel per clock, back to back, while the output is not stalled. The pipe is
// two set-up stages, then a row of FRAC_BITS+1 division cells, each producing one
// quotient bit of saturation and of hue; the last cell is the output register.
// The whole pipe holds while a result waits and ready is low.
`default_nettype none
module rgb_to_hsl #(
    parameter int FRAC_BITS = rth_pkg::FRAC_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rth_pix_if.sink    pix,
    rth_hsl_if.source  hsl
);
    import rth_pkg::*;

    localparam int W = FRAC_BITS + 4;
    localparam int N = FRAC_BITS + 1;

    logic en;

    ctl_t               ctl   [N+1];
    logic [FRAC_BITS:0] light [N+1];
    logic [W-1:0]       rem_s [N+1];
    logic [W-1:0]       div_s [N+1];
    logic [W-1:0]       rem_h [N+1];
    logic [W-1:0]       div_h [N+1];
    logic [FRAC_BITS:0] q_s   [N+1];
    logic [FRAC_BITS:0] q_h   [N+1];

    assign en        = !ctl[N].valid || hsl.ready;
    assign pix.ready = en;

    rth_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (pix.valid),
        .red      (pix.red),
        .green    (pix.green),
        .blue     (pix.blue),
        .ctl      (ctl[0]),
        .light    (light[0]),
        .rem_s    (rem_s[0]),
        .div_s    (div_s[0]),
        .rem_h    (rem_h[0]),
        .div_h    (div_h[0])
    );
    assign q_s[0] = '0;
    assign q_h[0] = '0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        rth_div_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .ctl_in    (ctl[i]),
            .light_in  (light[i]),
            .rem_s_in  (rem_s[i]),
            .div_s_in  (div_s[i]),
            .rem_h_in  (rem_h[i]),
            .div_h_in  (div_h[i]),
            .q_s_in    (q_s[i]),
            .q_h_in    (q_h[i]),
            .ctl_reg   (ctl[i+1]),
            .light_reg (light[i+1]),
            .rem_s_reg (rem_s[i+1]),
            .div_s_reg (div_s[i+1]),
            .rem_h_reg (rem_h[i+1]),
            .div_h_reg (div_h[i+1]),
            .q_s_reg   (q_s[i+1]),
            .q_h_reg   (q_h[i+1])
        );
    end

    // leftover remainders and divisors of the last cell are not needed
    assign hsl.valid          = ctl[N].valid;
    assign hsl.lightness      = light[N];
    assign hsl.saturation_out = ctl[N].grey ? '0 : q_s[N];
    assign hsl.hue_out        = ctl[N].grey ? '0 : q_h[N][FRAC_BITS-1:0];
endmodule
`default_nettype wire

/* rtl/core/rth_check.sv */
// Port-level checks for the RGB to HSL converter, bound to the top level.
`default_nettype none
module rth_check #(
    parameter int FRAC_BITS = rth_pkg::FRAC_BITS_DEF
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [FRAC_BITS:0]    lightness,
    input wire logic [FRAC_BITS:0]    saturation_out,
    input wire logic [FRAC_BITS-1:0]  hue_out
);
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hue_out)
        && $stable(saturation_out) && $stable(lightness))
        else $error("result item changed while stalled");

    a_light: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> lightness <= ONE)
        else $error("lightness above one");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> saturation_out <= ONE)
        else $error("saturation above one");

    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturation_out == '0 |-> hue_out == '0)
        else $error("hue set on grey pixel");
endmodule

bind rgb_to_hsl rth_check #(.FRAC_BITS(FRAC_BITS)) u_rth_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (hsl.valid),
    .out_ready      (hsl.ready),
    .lightness      (hsl.lightness),
    .saturation_out (hsl.saturation_out),
    .hue_out        (hsl.hue_out)
);
`default_nettype wire

/* test/rgb_to_hsl_tb.sv */
// Testbench for the RGB to HSL converter: random and directed pixels, scoreboard check.
`timescale 1ns / 100ps
`default_nettype none

class hsl_scoreboard;
    typedef struct {
        logic [16:0] lightness;
        logic [16:0] saturation;
        logic [15:0] hue;
    } hsl_t;

    hsl_t pending[$];
    int   errors;

    function logic [16:0] clamp(logic [16:0] v);
        return (v > 17'd65536) ? 17'd65536 : v;
    endfunction

    function void note_pixel(logic [16:0] red, logic [16:0] green, logic [16:0] blue);
        longint unsigned r, g, b, mx, mn, sum, delta, other, dv, part, num, base;
        bit plus;
        hsl_t e;
        r = clamp(red);
        g = clamp(green);
        b = clamp(blue);
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        sum = mx + mn;
        delta = mx - mn;
        other = 131072 - sum;
        dv = (sum < other) ? sum : other;
        e.lightness = 17'(sum >> 1);
        e.saturation = 0;
        e.hue = 0;
        if (delta != 0)
        begin
            if (dv != 0)
                e.saturation = 17'((delta * 65536) / dv);
            if (r >= g && g >= b)
            begin
                base = 0; plus = 1; part = g - mn;
            end
            else if (g >= r && r >= b)
            begin
                base = 2; plus = 0; part = r - mn;
            end
            else if (g >= b && b >= r)
            begin
                base = 2; plus = 1; part = b - mn;
            end
            else if (b >= g && g >= r)
            begin
                base = 4; plus = 0; part = g - mn;
            end
            else if (b >= r && r >= g)
            begin
                base = 4; plus = 1; part = r - mn;
            end
            else
            begin
                base = 6; plus = 0; part = b - mn;
            end
            num = base * delta;
            num = plus ? num + part : num - part;
            e.hue = 16'((num * 65536) / (6 * delta));
        end
        pending.push_back(e);
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    task check_result(logic [16:0] l, logic [16:0] s, logic [15:0] h);
        hsl_t e;
        if (pending.size() == 0)
        begin
            report("result with none expected");
            return;
        end
        e = pending.pop_front();
        if (l !== e.lightness)
            report($sformatf("lightness %0d, expected %0d", l, e.lightness));
        if (s !== e.saturation)
            report($sformatf("saturation %0d, expected %0d", s, e.saturation));
        if (h !== e.hue)
            report($sformatf("hue %0d, expected %0d", h, e.hue));
    endtask
endclass

module rgb_to_hsl_tb;
    import rth_pkg::*;

    logic clk;
    logic rst_n;
    int   cycles;

    rth_pix_if #(16) pix();
    rth_hsl_if #(16) hsl();

    rgb_to_hsl i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix.sink),
        .hsl   (hsl.source)
    );

    hsl_scoreboard sb = new();

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 200000)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pix.valid && pix.ready)
            sb.note_pixel(pix.red, pix.green, pix.blue);
        if (rst_n && hsl.valid && hsl.ready)
            sb.check_result(hsl.lightness, hsl.saturation_out, hsl.hue_out);
    end

    // receiver: stall pattern in phases
    initial
    begin
        int mode;
        hsl.ready = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 200))
            begin
                @(posedge clk);
                case (mode)
                    0: hsl.ready <= 1;
                    1: hsl.ready <= ($urandom_range(0, 3) != 0);
                    2: hsl.ready <= ($urandom_range(0, 3) == 0);
                    default: hsl.ready <= (cycles % 5) < 3;
                endcase
            end
        end
    end

    function logic [16:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom_range(65537, 131071));
            3: return 17'($urandom_range(65520, 65536));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task send_pixel(logic [16:0] r, logic [16:0] g, logic [16:0] b);
        pix.valid <= 1;
        pix.red   <= r;
        pix.green <= g;
        pix.blue  <= b;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
    endtask

    task idle_gap(int n);
        pix.valid <= 0;
        repeat (n) @(posedge clk);
    endtask

    initial
    begin
        logic [16:0] v;
        int burst;
        int items;
        pix.valid = 0;
        pix.red = 0;
        pix.green = 0;
        pix.blue = 0;
        rst_n = 0;
        cycles = 0;
        items = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: black, white, greys, primaries, ties, over-range, each sextant
        send_pixel(0, 0, 0);
        send_pixel(65536, 65536, 65536);
        send_pixel(131071, 131071, 131071);
        send_pixel(32768, 32768, 32768);
        send_pixel(65536, 0, 0);
        send_pixel(0, 65536, 0);
        send_pixel(0, 0, 65536);
        send_pixel(65536, 65536, 0);
        send_pixel(0, 65536, 65536);
        send_pixel(65536, 0, 65536);
        send_pixel(131071, 0, 70000);
        send_pixel(60000, 30000, 10000);
        send_pixel(30000, 60000, 10000);
        send_pixel(10000, 60000, 30000);
        send_pixel(10000, 30000, 60000);
        send_pixel(30000, 10000, 60000);
        send_pixel(60000, 10000, 30000);
        send_pixel(65536, 1, 0);
        send_pixel(1, 0, 0);
        send_pixel(65535, 65536, 65536);
        send_pixel(17'h1FFFF, 17'h15555, 17'h0AAAA);
        idle_gap(3);

        while (items < 1300)
        begin
            burst = $urandom_range(1, 30);
            repeat (burst)
            begin
                v = rand_comp();
                case ($urandom_range(0, 5))
                    0: send_pixel(v, v, rand_comp());
                    1: send_pixel(v, rand_comp(), v);
                    2: send_pixel(v, v, v);
                    default: send_pixel(rand_comp(), rand_comp(), rand_comp());
                endcase
                items++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 8));
        end
        pix.valid <= 0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
rtl/core/rth_pkg.sv
rtl/core/rth_if.sv
rtl/core/rth_prep.sv
rtl/core/rth_div_cell.sv
rtl/core/rgb_to_hsl.sv
rtl/core/rth_check.sv
test/rgb_to_hsl_tb.sv
